// ----- rtl/core/aewf_pkg.sv -----
// package for the embedded audio word formatter
// holds the shared constants, the queue entry type and the word packing helpers
// no dependencies
`timescale 1ns / 1ps

package aewf_pkg;

  localparam int CHANNEL_COUNT = 4;
  localparam int BLOCK_FRAMES  = 192;
  localparam int STATUS_BITS   = 184;
  localparam int SAMPLE_W      = 20;
  localparam int WORD_W        = 10;
  localparam int CFG_DATA_W    = 64;
  localparam int HIGH_W        = 56;
  localparam int CH_W          = 2;
  localparam int FIFO_DEPTH    = 2;

  localparam logic [7:0] CRC_SEED = 8'hFF;
  localparam logic [7:0] CRC_TAPS = 8'h1D;
  localparam logic [7:0] LAST_FRAME = 8'(BLOCK_FRAMES - 1);
  localparam logic [7:0] FIRST_CRC_FRAME = 8'(STATUS_BITS);
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNEL_COUNT - 1);

  // configuration register indexes
  localparam logic [1:0] REG_STATUS_LOW  = 2'd0;
  localparam logic [1:0] REG_STATUS_MID  = 2'd1;
  localparam logic [1:0] REG_STATUS_HIGH = 2'd2;

  localparam logic [CFG_DATA_W-1:0] STATUS_LOW_RST  = 64'd513;
  localparam logic [CFG_DATA_W-1:0] STATUS_MID_RST  = 64'd0;
  localparam logic [HIGH_W-1:0]     STATUS_HIGH_RST = 56'd0;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // one frame waiting between the front and the back
  typedef struct packed {
    sample_t [CHANNEL_COUNT-1:0] sample;
    logic                        zbit;
    logic                        cbit;
  } aewf_entry_t;

  // b9 is always the inverse of b8
  function automatic logic [WORD_W-1:0] with_b9(input logic [8:0] w);
    return {~w[8], w};
  endfunction

endpackage

// ----- rtl/core/embedded_audio_word_formatter.sv -----
// top level of the embedded audio word formatter (aes audio into 10-bit data words)
// instantiates aewf_front, aewf_fifo and aewf_back; depends on aewf_pkg
//
//   channel  handshake            payload
//   in       in_push / in_full    in_sample_one .. in_sample_four (20-bit signed)
//   out      out_empty / out_pop  out_channel_number, out_word_first/second/third,
//                                 out_last_of_frame
//   cfg      cfg_valid/cfg_ready  cfg_index (register), cfg_data (64-bit)
//
// one frame transaction yields four result transactions, at most one per cycle; the back
// end's single word packer sets that rate
// the queue holds two frames, the one being unpacked included, so the front takes one
// more frame while the back end is stalled on out_pop
// an accepted frame passes the queue, then the output register, before its first result shows
// synchronous active-low reset clears block position and queue, seeds crc with 0xff, status low to 0x201
`timescale 1ns / 1ps

module embedded_audio_word_formatter (
  input  logic                                clk,
  input  logic                                rst_n,
  // frame input
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [aewf_pkg::SAMPLE_W-1:0] in_sample_one,
  input  logic signed [aewf_pkg::SAMPLE_W-1:0] in_sample_two,
  input  logic signed [aewf_pkg::SAMPLE_W-1:0] in_sample_three,
  input  logic signed [aewf_pkg::SAMPLE_W-1:0] in_sample_four,
  // word output
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [aewf_pkg::CH_W-1:0]           out_channel_number,
  output logic [aewf_pkg::WORD_W-1:0]         out_word_first,
  output logic [aewf_pkg::WORD_W-1:0]         out_word_second,
  output logic [aewf_pkg::WORD_W-1:0]         out_word_third,
  output logic                                out_last_of_frame,
  // channel status registers
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [aewf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  aewf_pkg::sample_t [aewf_pkg::CHANNEL_COUNT-1:0] sample;
  aewf_pkg::aewf_entry_t front_entry;
  aewf_pkg::aewf_entry_t head_entry;
  logic                  accept;
  logic                  head_valid;
  logic                  head_pop;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // channel 1 sits at index 0
  assign sample[0] = unsigned'(in_sample_one);
  assign sample[1] = unsigned'(in_sample_two);
  assign sample[2] = unsigned'(in_sample_three);
  assign sample[3] = unsigned'(in_sample_four);

  assign accept = in_push && !in_full;

  // front: block position, c bit and crc, computed as the frame arrives
  aewf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (accept),
    .sample    (sample),
    .entry     (front_entry)
  );

  // short queue decouples frame intake from word output
  aewf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .wr_entry (front_entry),
    .full     (in_full),
    .pop      (head_pop),
    .nonempty (head_valid),
    .rd_entry (head_entry)
  );

  // back: one channel's three words per cycle into the output register, while not stalled on out_pop
  aewf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head           (head_entry),
    .head_pop       (head_pop),
    .empty          (out_empty),
    .pop            (out_pop),
    .channel_number (out_channel_number),
    .word_first     (out_word_first),
    .word_second    (out_word_second),
    .word_third     (out_word_third),
    .last_of_frame  (out_last_of_frame)
  );

endmodule

// ----- rtl/core/aewf_front.sv -----
// front end: accepts frames, tracks the block position and the status crc
// holds the channel status registers; depends on aewf_pkg
`timescale 1ns / 1ps

module aewf_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [1:0]                        cfg_index,
  input  logic [aewf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              push,
  input  aewf_pkg::sample_t [aewf_pkg::CHANNEL_COUNT-1:0] sample,
  output aewf_pkg::aewf_entry_t             entry
);

  logic [aewf_pkg::CFG_DATA_W-1:0] status_low_r;
  logic [aewf_pkg::CFG_DATA_W-1:0] status_mid_r;
  logic [aewf_pkg::HIGH_W-1:0]     status_high_r;
  logic [7:0] frame_r, frame_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] crc_in;
  logic [aewf_pkg::STATUS_BITS-1:0] status_vec;
  logic       in_status;
  logic       cbit;
  logic       mask;

  assign status_vec = {status_high_r, status_mid_r, status_low_r};
  assign in_status  = (frame_r < aewf_pkg::FIRST_CRC_FRAME);
  assign crc_in     = (frame_r == 8'd0) ? aewf_pkg::CRC_SEED : crc_r;

  always_comb begin
    crc_nxt = crc_r;
    if (in_status) begin
      cbit    = status_vec[frame_r];
      mask    = cbit ^ crc_in[7];
      crc_nxt = {crc_in[6:0], 1'b0} ^ (mask ? aewf_pkg::CRC_TAPS : 8'd0);
    end else begin
      // crc byte goes out msb first; the crc frames start on a multiple of eight
      cbit = crc_r[3'd7 - frame_r[2:0]];
      mask = 1'b0;
    end
    frame_nxt = (frame_r == aewf_pkg::LAST_FRAME) ? 8'd0 : frame_r + 8'd1;
  end

  assign entry.sample = sample;
  assign entry.zbit   = (frame_r == 8'd0);
  assign entry.cbit   = cbit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_low_r  <= aewf_pkg::STATUS_LOW_RST;
      status_mid_r  <= aewf_pkg::STATUS_MID_RST;
      status_high_r <= aewf_pkg::STATUS_HIGH_RST;
      frame_r       <= 8'd0;
      crc_r         <= aewf_pkg::CRC_SEED;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          aewf_pkg::REG_STATUS_LOW:  status_low_r  <= cfg_data;
          aewf_pkg::REG_STATUS_MID:  status_mid_r  <= cfg_data;
          aewf_pkg::REG_STATUS_HIGH: status_high_r <= cfg_data[aewf_pkg::HIGH_W-1:0];
          default: ;
        endcase
      end
      if (push) begin
        frame_r <= frame_nxt;
        crc_r   <= crc_nxt;
      end
    end
  end

endmodule

// ----- rtl/core/aewf_fifo.sv -----
// two-entry frame queue between the front and the back
// depends on aewf_pkg
`timescale 1ns / 1ps

module aewf_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  aewf_pkg::aewf_entry_t wr_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  nonempty,
  output aewf_pkg::aewf_entry_t rd_entry
);

  aewf_pkg::aewf_entry_t mem [aewf_pkg::FIFO_DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'(aewf_pkg::FIFO_DEPTH));
  assign nonempty = (count_r != 2'd0);
  assign rd_entry = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (!push && pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/aewf_back.sv -----
// back end: walks the channels of the head frame and packs the three words
// output register feeds the result queue ports; depends on aewf_pkg
`timescale 1ns / 1ps

module aewf_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_valid,
  input  aewf_pkg::aewf_entry_t           head,
  output logic                            head_pop,
  output logic                            empty,
  input  logic                            pop,
  output logic [aewf_pkg::CH_W-1:0]       channel_number,
  output logic [aewf_pkg::WORD_W-1:0]     word_first,
  output logic [aewf_pkg::WORD_W-1:0]     word_second,
  output logic [aewf_pkg::WORD_W-1:0]     word_third,
  output logic                            last_of_frame
);

  logic [aewf_pkg::CH_W-1:0] ch_r;
  logic                      out_valid_r;
  logic                      load;
  aewf_pkg::sample_t         s;
  logic [8:0]                x0, x1, x2;
  logic                      parity;

  assign load     = head_valid && (!out_valid_r || pop);
  assign head_pop = load && (ch_r == aewf_pkg::LAST_CH);
  assign empty    = !out_valid_r;

  always_comb begin
    s      = head.sample[ch_r];
    parity = ^{head.zbit, ch_r, s, head.cbit};
    x0     = {s[5:0], ch_r, head.zbit};
    x1     = s[14:6];
    x2     = {parity, head.cbit, 2'b00, s[19:15]};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      channel_number <= ch_r;
      word_first     <= aewf_pkg::with_b9(x0);
      word_second    <= aewf_pkg::with_b9(x1);
      word_third     <= aewf_pkg::with_b9(x2);
      last_of_frame  <= (ch_r == aewf_pkg::LAST_CH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        ch_r        <= head_pop ? '0 : ch_r + aewf_pkg::CH_W'(1);
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
